>>> hw/rtl/tapid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tapid_pkg
// Shared types, register codes and constants for the three-axis attitude PID.
// ---------------------------------------------------------------------------
package tapid_pkg;

   localparam int DEFAULT_AXIS_COUNT = 3;
   localparam int DEFAULT_SUM_WIDTH  = 32;
   localparam int AXIS_MAX           = 3;

   localparam int ANGLE_W = 15;   // Q2.12 angle
   localparam int GAIN_W  = 20;   // unsigned Q4.16 gain
   localparam int CMD_W   = 16;   // Q1.14 command
   localparam int ERR_W   = 16;   // setpoint - measured
   localparam int DIFF_W  = 17;   // error - last error
   localparam int CSR_W   = 3;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic        [GAIN_W-1:0]  gain_type;
   typedef logic signed [CMD_W-1:0]   cmd_type;
   typedef logic signed [ERR_W-1:0]   error_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_ROLL_SETPOINT  = 3'd0,
      CSR_PITCH_SETPOINT = 3'd1,
      CSR_YAW_SETPOINT   = 3'd2,
      CSR_KP_ROLL_PITCH  = 3'd3,
      CSR_KD_ROLL_PITCH  = 3'd4,
      CSR_KP_YAW         = 3'd5,
      CSR_KD_YAW         = 3'd6,
      CSR_KI_TIMES_STEP  = 3'd7
   } csr_index_type;

   // register reset values
   localparam angle_type RST_ROLL_SETPOINT  = 15'sd2145;
   localparam angle_type RST_PITCH_SETPOINT = 15'sd2145;
   localparam angle_type RST_YAW_SETPOINT   = 15'sd2048;
   localparam gain_type  RST_KP_ROLL_PITCH  = 20'd52429;
   localparam gain_type  RST_KD_ROLL_PITCH  = 20'd32768;
   localparam gain_type  RST_KP_YAW         = 20'd32768;
   localparam gain_type  RST_KD_YAW         = 20'd19661;
   localparam gain_type  RST_KI_TIMES_STEP  = 20'd66;

   // command limits, Q1.14
   localparam cmd_type CMD_POS_ONE = 16'sd16384;
   localparam cmd_type CMD_NEG_ONE = -16'sd16384;

   // per-lane pipeline control from the top level
   typedef struct packed {
      logic accept;   // transaction taken: stage A loads, axis state updates
      logic en_b;     // stage B advances
      logic en_c;     // stage C advances
   } pipe_ctrl_type;

endpackage : tapid_pkg
`default_nettype wire

>>> hw/rtl/tapid_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tapid_lane
// One axis of the PID: error, saturating integral, derivative, gain products
// and the clamp/round to a Q1.14 command. Three register stages.
// ---------------------------------------------------------------------------
module tapid_lane #(
   parameter int SUM_WIDTH = tapid_pkg::DEFAULT_SUM_WIDTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  tapid_pkg::pipe_ctrl_type ctrl,
   input  tapid_pkg::angle_type    setpoint,
   input  tapid_pkg::angle_type    measured,
   input  tapid_pkg::gain_type     kp,
   input  tapid_pkg::gain_type     kd,
   input  tapid_pkg::gain_type     ki,
   output tapid_pkg::cmd_type      cmd
);
   import tapid_pkg::*;

   // rounding bias folded in at stage C, so limits shift by the same amount
   localparam logic signed [42:0] RND_HI = 43'sd268443648;   //  2^28 + 8192
   localparam logic signed [42:0] RND_LO = -43'sd268427264;  // -2^28 + 8192

   // axis state
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   error_type                   last_ff, last_in;

   // stage A
   error_type                   err;
   diff_type                    diff;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   error_type                   err_a_ff;
   diff_type                    diff_a_ff;
   logic signed [SUM_WIDTH-1:0] sum_a_ff;

   // stage B
   logic        [SUM_WIDTH-1:0] sum_bits;
   logic        [SUM_WIDTH-1:0] mag;
   logic        [63:0]          mag64;
   logic signed [36:0]          p_b_in, p_b_ff;
   logic signed [37:0]          d_b_in, d_b_ff;
   logic        [39:0]          lo_b_in, lo_b_ff;
   logic        [39:0]          hi_b_in, hi_b_ff;
   logic                        over_b_in, over_b_ff;
   logic                        neg_b_ff;

   // stage C
   logic        [60:0]          ip;
   logic                        cap_hit;
   logic        [40:0]          i_mag;
   logic signed [41:0]          iterm_c_in, iterm_c_ff;
   logic signed [38:0]          pd_c_in, pd_c_ff;

   // output
   logic signed [42:0]          rnd;

   // ---- stage A: error, integral, derivative ----
   assign err      = {setpoint[ANGLE_W-1], setpoint} - {measured[ANGLE_W-1], measured};
   assign diff     = {err[ERR_W-1], err} - {last_ff[ERR_W-1], last_ff};
   assign sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff}
                   + {{(SUM_WIDTH + 1 - ERR_W){err[ERR_W-1]}}, err};

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = {sum_wide[SUM_WIDTH], {(SUM_WIDTH - 1){~sum_wide[SUM_WIDTH]}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign sum_in  = ctrl.accept ? sum_sat : sum_ff;
   assign last_in = ctrl.accept ? err : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         last_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         err_a_ff  <= err;
         diff_a_ff <= diff;
         sum_a_ff  <= sum_sat;
      end
   end

   // ---- stage B: gain products; integral term split into 20-bit halves ----
   assign sum_bits  = sum_a_ff;
   assign mag       = sum_bits[SUM_WIDTH-1] ? (~sum_bits + SUM_WIDTH'(1)) : sum_bits;
   assign mag64     = 64'(mag);
   assign p_b_in    = $signed({1'b0, kp}) * err_a_ff;
   assign d_b_in    = $signed({1'b0, kd}) * diff_a_ff;
   assign lo_b_in   = ki * mag64[19:0];
   assign hi_b_in   = ki * mag64[39:20];
   assign over_b_in = (mag64[63:40] != '0) && (ki != '0);

   always_ff @(posedge clock) begin
      if (ctrl.en_b) begin
         p_b_ff    <= p_b_in;
         d_b_ff    <= d_b_in;
         lo_b_ff   <= lo_b_in;
         hi_b_ff   <= hi_b_in;
         over_b_ff <= over_b_in;
         neg_b_ff  <= sum_bits[SUM_WIDTH-1];
      end
   end

   // ---- stage C: cap the integral term at 2^40, sum P and D plus bias ----
   assign ip      = {1'b0, hi_b_ff, 20'd0} + {21'd0, lo_b_ff};
   assign cap_hit = over_b_ff || (ip > 61'h100_0000_0000);
   assign i_mag   = cap_hit ? {1'b1, 40'd0} : ip[40:0];

   always_comb begin
      if (neg_b_ff) begin
         iterm_c_in = -$signed({1'b0, i_mag});
      end else begin
         iterm_c_in = $signed({1'b0, i_mag});
      end
   end

   assign pd_c_in = {{2{p_b_ff[36]}}, p_b_ff} + {d_b_ff[37], d_b_ff} + 39'sd8192;

   always_ff @(posedge clock) begin
      if (ctrl.en_c) begin
         iterm_c_ff <= iterm_c_in;
         pd_c_ff    <= pd_c_in;
      end
   end

   // ---- clamp to +-1 and round to Q1.14 ----
   assign rnd = {iterm_c_ff[41], iterm_c_ff} + {{4{pd_c_ff[38]}}, pd_c_ff};

   always_comb begin
      if (rnd >= RND_HI) begin
         cmd = CMD_POS_ONE;
      end else if (rnd <= RND_LO) begin
         cmd = CMD_NEG_ONE;
      end else begin
         cmd = rnd[29:14];
      end
   end

endmodule : tapid_lane
`default_nettype wire

>>> hw/rtl/tapid_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tapid_merge
// Output register: maps axis commands onto the surfaces, right aileron is
// the negated roll command.
// ---------------------------------------------------------------------------
module tapid_merge (
   input  wire                clock,
   input  wire                load,
   input  tapid_pkg::cmd_type cmd [tapid_pkg::AXIS_MAX],
   output tapid_pkg::cmd_type left_aileron,
   output tapid_pkg::cmd_type right_aileron,
   output tapid_pkg::cmd_type elevator,
   output tapid_pkg::cmd_type rudder
);
   import tapid_pkg::*;

   cmd_type left_ff, right_ff, elev_ff, rudder_ff;
   cmd_type right_in;

   // roll command is within +-1, so the negation always fits
   assign right_in = -cmd[0];

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff   <= cmd[0];
         right_ff  <= right_in;
         elev_ff   <= cmd[1];
         rudder_ff <= cmd[2];
      end
   end

   assign left_aileron  = left_ff;
   assign right_aileron = right_ff;
   assign elevator      = elev_ff;
   assign rudder        = rudder_ff;

endmodule : tapid_merge
`default_nettype wire

>>> hw/rtl/three_axis_attitude_pid.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// three_axis_attitude_pid
// Roll/pitch/yaw PID with saturating integrals and +-1 output clamp; three
// parallel axis lanes feed one output register.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_*     in         req_valid/req_ready    roll/pitch/yaw measured, Q2.12
//  rsp_*     out        rsp_valid/rsp_ready    ailerons, elevator, rudder, Q1.14
//  csr_*     in         csr_valid/csr_ready    csr_index (0..7), csr_wdata[19:0]
//
//  Throughput: one transaction per cycle while rsp_ready stays high. From accept
//  to rsp_valid: stages A, B, C in each lane, then the output register.
//  The integral and last-error state updates at the accept edge, so the next
//  transaction can follow in the very next cycle.
//  Stalls: each stage advances when its successor is empty or advancing, so
//  bubbles collapse and req_ready stays high while any stage is free.
//  Reset clears the valid chain, the axis state and the registers to their
//  defaults. csr_ready is always high; write only while the block is idle.
// ---------------------------------------------------------------------------
module three_axis_attitude_pid #(
   parameter int AXIS_COUNT = tapid_pkg::DEFAULT_AXIS_COUNT,
   parameter int SUM_WIDTH  = tapid_pkg::DEFAULT_SUM_WIDTH
) (
   input  wire                          clock,
   input  wire                          reset,
   // measurement transactions
   input  wire                          req_valid,
   output logic                         req_ready,
   input  tapid_pkg::angle_type         req_roll_measured,
   input  tapid_pkg::angle_type         req_pitch_measured,
   input  tapid_pkg::angle_type         req_yaw_measured,
   // command transactions
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output tapid_pkg::cmd_type           rsp_left_aileron,
   output tapid_pkg::cmd_type           rsp_right_aileron,
   output tapid_pkg::cmd_type           rsp_elevator,
   output tapid_pkg::cmd_type           rsp_rudder,
   // register writes
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  tapid_pkg::csr_index_type     csr_index,
   input  tapid_pkg::gain_type          csr_wdata
);
   import tapid_pkg::*;

   // configuration registers
   angle_type roll_sp_ff, pitch_sp_ff, yaw_sp_ff;
   gain_type  kp_rp_ff, kd_rp_ff, kp_yaw_ff, kd_yaw_ff, ki_ff;
   logic      csr_write;

   // valid chain
   logic v_a_ff, v_a_in;
   logic v_b_ff, v_b_in;
   logic v_c_ff, v_c_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic en_a, en_b, en_c, en_out;
   logic accept;
   pipe_ctrl_type ctrl;

   // per-axis lane hookup
   angle_type sp_arr   [AXIS_MAX];
   angle_type meas_arr [AXIS_MAX];
   gain_type  kp_arr   [AXIS_MAX];
   gain_type  kd_arr   [AXIS_MAX];
   cmd_type   cmd_arr  [AXIS_MAX];

   // ------------------------------------------------------------------
   // Register file. Setpoints keep the low 15 bits of the write data.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_sp_ff  <= RST_ROLL_SETPOINT;
         pitch_sp_ff <= RST_PITCH_SETPOINT;
         yaw_sp_ff   <= RST_YAW_SETPOINT;
         kp_rp_ff    <= RST_KP_ROLL_PITCH;
         kd_rp_ff    <= RST_KD_ROLL_PITCH;
         kp_yaw_ff   <= RST_KP_YAW;
         kd_yaw_ff   <= RST_KD_YAW;
         ki_ff       <= RST_KI_TIMES_STEP;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROLL_SETPOINT:  roll_sp_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_PITCH_SETPOINT: pitch_sp_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_YAW_SETPOINT:   yaw_sp_ff   <= csr_wdata[ANGLE_W-1:0];
            CSR_KP_ROLL_PITCH:  kp_rp_ff    <= csr_wdata;
            CSR_KD_ROLL_PITCH:  kd_rp_ff    <= csr_wdata;
            CSR_KP_YAW:         kp_yaw_ff   <= csr_wdata;
            CSR_KD_YAW:         kd_yaw_ff   <= csr_wdata;
            CSR_KI_TIMES_STEP:  ki_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage moves when the next one is empty or
   // moving itself.
   // ------------------------------------------------------------------
   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en_c      = !v_c_ff || en_out;
   assign en_b      = !v_b_ff || en_c;
   assign en_a      = !v_a_ff || en_b;
   assign req_ready = en_a;
   assign accept    = req_valid && req_ready;

   assign v_a_in       = en_a   ? accept : v_a_ff;
   assign v_b_in       = en_b   ? v_a_ff : v_b_ff;
   assign v_c_in       = en_c   ? v_b_ff : v_c_ff;
   assign rsp_valid_in = en_out ? v_c_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff       <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_a_ff       <= v_a_in;
         v_b_ff       <= v_b_in;
         v_c_ff       <= v_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign ctrl.accept = accept;
   assign ctrl.en_b   = en_b;
   assign ctrl.en_c   = en_c;

   // ------------------------------------------------------------------
   // Lanes: roll and pitch share gains, yaw has its own; ki is common.
   // ------------------------------------------------------------------
   assign sp_arr[0]   = roll_sp_ff;
   assign sp_arr[1]   = pitch_sp_ff;
   assign sp_arr[2]   = yaw_sp_ff;
   assign meas_arr[0] = req_roll_measured;
   assign meas_arr[1] = req_pitch_measured;
   assign meas_arr[2] = req_yaw_measured;
   assign kp_arr[0]   = kp_rp_ff;
   assign kp_arr[1]   = kp_rp_ff;
   assign kp_arr[2]   = kp_yaw_ff;
   assign kd_arr[0]   = kd_rp_ff;
   assign kd_arr[1]   = kd_rp_ff;
   assign kd_arr[2]   = kd_yaw_ff;

   for (genvar i = 0; i < AXIS_MAX; i++) begin : g_axis
      if (i < AXIS_COUNT) begin : g_lane
         tapid_lane #(
            .SUM_WIDTH (SUM_WIDTH)
         ) u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .setpoint (sp_arr[i]),
            .measured (meas_arr[i]),
            .kp       (kp_arr[i]),
            .kd       (kd_arr[i]),
            .ki       (ki_ff),
            .cmd      (cmd_arr[i])
         );
      end else begin : g_off
         // axis not built: command stays zero
         assign cmd_arr[i] = '0;
      end
   end

   // ------------------------------------------------------------------
   // Merge into the output register
   // ------------------------------------------------------------------
   tapid_merge u_merge (
      .clock         (clock),
      .load          (en_out),
      .cmd           (cmd_arr),
      .left_aileron  (rsp_left_aileron),
      .right_aileron (rsp_right_aileron),
      .elevator      (rsp_elevator),
      .rudder        (rsp_rudder)
   );

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_aileron_mirror : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_aileron == -rsp_left_aileron))
      else $error("right aileron is not the negated left aileron");

   a_cmd_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_aileron <= CMD_POS_ONE) && (rsp_left_aileron >= CMD_NEG_ONE)
                 && (rsp_elevator <= CMD_POS_ONE) && (rsp_elevator >= CMD_NEG_ONE)
                 && (rsp_rudder <= CMD_POS_ONE) && (rsp_rudder >= CMD_NEG_ONE))
      else $error("command outside +-1");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      (v_a_ff && v_b_ff && v_c_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while every stage is occupied");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> v_a_ff)
      else $error("accepted transaction did not enter stage A");

   a_unused_axis : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (AXIS_COUNT > 2) || (rsp_rudder == '0))
      else $error("rudder active on a build without the yaw lane");

endmodule : three_axis_attitude_pid
`default_nettype wire

>>> test/tb_three_axis_attitude_pid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_three_axis_attitude_pid
// Self-checking bench for the three-axis attitude PID. A queue-fed driver
// offers measurement transactions and a clocked monitor compares every
// command transaction with a bit-exact software PID kept in step with the
// register writes. Covers directed corners (rounding ties, clamp edges,
// full-scale swings), random register sets with random-walk attitude
// traffic, backpressure that fills the pipe, and a held error that builds
// the integral up and then winds it back down.
// ---------------------------------------------------------------------------
module tb_three_axis_attitude_pid;
   import tapid_pkg::*;

   localparam int AXES     = DEFAULT_AXIS_COUNT;
   localparam int SUM_BITS = DEFAULT_SUM_WIDTH;

   localparam int ANGLE_MAX = 2 ** (ANGLE_W - 1) - 1;
   localparam int ANGLE_MIN = -(2 ** (ANGLE_W - 1));
   localparam int GAIN_MAX  = 2 ** GAIN_W - 1;

   // predictor arithmetic, all in Q.28 after the gain product
   localparam longint TERM_LIMIT = 64'sd1 <<< 40;
   localparam longint ONE_Q28    = 64'sd1 <<< 28;
   localparam longint SUM_HI     = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
   localparam longint SUM_LO     = -SUM_HI - 64'sd1;
   localparam int     FRAC_DROP  = 14;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_DROP - 1);

   localparam int STALL_CYCLES   = 120;     // receiver hold-off for pressure
   localparam int WATCHDOG_LIMIT = 3000;    // cycles with no transaction at all
   localparam int WINDUP_ITEMS   = 12;      // held-error steps per direction
   localparam int MAX_PRINTED    = 40;

   typedef struct packed {
      angle_type roll;
      angle_type pitch;
      angle_type yaw;
   } attitude_type;

   typedef struct packed {
      cmd_type left_aileron;
      cmd_type right_aileron;
      cmd_type elevator;
      cmd_type rudder;
   } command_set_type;

   typedef struct {
      angle_type roll_sp;
      angle_type pitch_sp;
      angle_type yaw_sp;
      gain_type  kp_rp;
      gain_type  kd_rp;
      gain_type  kp_yaw;
      gain_type  kd_yaw;
      gain_type  ki;
   } controller_settings_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value at time 0.
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid          = 1'b0;
   logic          req_ready;
   angle_type     req_roll_measured  = '0;
   angle_type     req_pitch_measured = '0;
   angle_type     req_yaw_measured   = '0;

   logic          rsp_valid;
   logic          rsp_ready          = 1'b0;
   cmd_type       rsp_left_aileron;
   cmd_type       rsp_right_aileron;
   cmd_type       rsp_elevator;
   cmd_type       rsp_rudder;

   logic          csr_valid          = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index          = CSR_ROLL_SETPOINT;
   gain_type      csr_wdata          = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   three_axis_attitude_pid #(
      .AXIS_COUNT(AXES),
      .SUM_WIDTH (SUM_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_roll_measured (req_roll_measured),
      .req_pitch_measured(req_pitch_measured),
      .req_yaw_measured  (req_yaw_measured),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_aileron  (rsp_left_aileron),
      .rsp_right_aileron (rsp_right_aileron),
      .rsp_elevator      (rsp_elevator),
      .rsp_rudder        (rsp_rudder),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   attitude_type    sample_queue [$];       // measurements not yet offered
   command_set_type expected_commands [$];  // predicted, not yet received
   attitude_type    current_sample;         // payload currently on req_*

   int samples_queued = 0;   // pushed by the stimulus
   int samples_taken  = 0;   // accepted by the block
   int commands_seen  = 0;
   int mismatch_count = 0;

   // idle shaping; the stimulus flips these per phase
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int req_gap   = 0;
   int rsp_gap   = 0;

   // pressure: stimulus bumps stall_requests, monitor serves each one
   int stall_requests = 0;
   int stalls_served  = 0;
   int stall_left     = 0;

   int stalled_cycles = 0;
   int drift [3] = '{0, 0, 0};   // random-walk offset of each axis

   // Software copy of the controller: registers and per-axis state.
   // Roll and pitch share kp/kd, so those land in lanes 0 and 1 together.
   angle_type setpoint [3];
   gain_type  kp_gain [3];
   gain_type  kd_gain [3];
   gain_type  ki_gain;
   longint    integral_sum [3];
   longint    last_error [3];

   // ---------------------------------------------------------------------
   // PID predictor
   // ---------------------------------------------------------------------

   // gain * x with both the operand and the product capped at 2^40
   function automatic longint scaled_term(gain_type g, longint x);
      longint unsigned mag;
      longint unsigned prod;
      if (x < 0) mag = -x;
      else mag = x;
      if (mag > TERM_LIMIT) mag = TERM_LIMIT;
      prod = mag * g;
      if (prod > TERM_LIMIT) prod = TERM_LIMIT;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   // Q.28 to Q1.14: clamp at +-1, otherwise round half up
   function automatic cmd_type to_command(longint acc);
      longint q;
      if (acc >= ONE_Q28) return CMD_POS_ONE;
      if (acc <= -ONE_Q28) return CMD_NEG_ONE;
      q = ((acc + ONE_Q28 + ROUND_HALF) >>> FRAC_DROP) - (ONE_Q28 >>> FRAC_DROP);
      return q[CMD_W-1:0];
   endfunction

   // one axis: update integral and last error, return the command
   function automatic cmd_type axis_command(int a, angle_type measured);
      longint err;
      longint total;
      longint delta;
      if (a >= AXES) return '0;
      err   = longint'(setpoint[a]) - longint'(measured);
      total = integral_sum[a] + err;
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      delta = err - last_error[a];
      integral_sum[a] = total;
      last_error[a]   = err;
      return to_command(scaled_term(kp_gain[a], err) + scaled_term(ki_gain, total)
                        + scaled_term(kd_gain[a], delta));
   endfunction

   task automatic predict_commands(attitude_type s);
      command_set_type c;
      cmd_type roll_out;
      roll_out        = axis_command(0, s.roll);
      c.left_aileron  = roll_out;
      c.right_aileron = -roll_out;
      c.elevator      = axis_command(1, s.pitch);
      c.rudder        = axis_command(2, s.yaw);
      expected_commands.push_back(c);
   endtask

   task automatic apply_register(csr_index_type idx, gain_type data);
      case (idx)
         CSR_ROLL_SETPOINT:  setpoint[0] = data[ANGLE_W-1:0];
         CSR_PITCH_SETPOINT: setpoint[1] = data[ANGLE_W-1:0];
         CSR_YAW_SETPOINT:   setpoint[2] = data[ANGLE_W-1:0];
         CSR_KP_ROLL_PITCH: begin
            kp_gain[0] = data;
            kp_gain[1] = data;
         end
         CSR_KD_ROLL_PITCH: begin
            kd_gain[0] = data;
            kd_gain[1] = data;
         end
         CSR_KP_YAW:         kp_gain[2] = data;
         CSR_KD_YAW:         kd_gain[2] = data;
         CSR_KI_TIMES_STEP:  ki_gain = data;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   task automatic report_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("[%0t] FAIL: %s", $realtime, msg);
   endtask

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic offer(int roll, int pitch, int yaw);
      attitude_type s;
      s.roll  = roll[ANGLE_W-1:0];
      s.pitch = pitch[ANGLE_W-1:0];
      s.yaw   = yaw[ANGLE_W-1:0];
      sample_queue.push_back(s);
      samples_queued++;
   endtask

   function automatic controller_settings_type make_settings(
      int roll_sp, int pitch_sp, int yaw_sp, int kp_rp, int kd_rp,
      int kp_yaw, int kd_yaw, int ki);
      controller_settings_type s;
      s.roll_sp  = roll_sp[ANGLE_W-1:0];
      s.pitch_sp = pitch_sp[ANGLE_W-1:0];
      s.yaw_sp   = yaw_sp[ANGLE_W-1:0];
      s.kp_rp    = kp_rp[GAIN_W-1:0];
      s.kd_rp    = kd_rp[GAIN_W-1:0];
      s.kp_yaw   = kp_yaw[GAIN_W-1:0];
      s.kd_yaw   = kd_yaw[GAIN_W-1:0];
      s.ki       = ki[GAIN_W-1:0];
      return s;
   endfunction

   function automatic int random_angle();
      int v;
      if ($urandom_range(0, 4) == 0) begin
         v = $urandom_range(0, 2 * ANGLE_MAX + 1);
         if (v > ANGLE_MAX) v -= 2 * (ANGLE_MAX + 1);
      end else begin
         v = $urandom_range(0, 25736);
         v -= 12868;
      end
      return v;
   endfunction

   // gains spread over every magnitude from tiny to full scale
   function automatic int random_gain();
      return $urandom & ((32'd1 << $urandom_range(0, GAIN_W)) - 1);
   endfunction

   function automatic controller_settings_type random_settings();
      return make_settings(random_angle(), random_angle(), random_angle(),
                           random_gain(), random_gain(), random_gain(),
                           random_gain(), random_gain());
   endfunction

   // one register write; returns at the accepting edge with csr_valid still up
   task automatic write_register(csr_index_type idx, gain_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
   endtask

   // all eight registers; setpoint writes carry junk in the unused top bits
   task automatic load_settings(controller_settings_type s);
      logic [GAIN_W-ANGLE_W-1:0] pad;
      logic [31:0]               noise;
      noise = $urandom;
      pad   = noise[GAIN_W-ANGLE_W-1:0];
      write_register(CSR_ROLL_SETPOINT, {pad, s.roll_sp});
      noise = $urandom;
      pad   = noise[GAIN_W-ANGLE_W-1:0];
      write_register(CSR_PITCH_SETPOINT, {pad, s.pitch_sp});
      noise = $urandom;
      pad   = noise[GAIN_W-ANGLE_W-1:0];
      write_register(CSR_YAW_SETPOINT, {pad, s.yaw_sp});
      write_register(CSR_KP_ROLL_PITCH, s.kp_rp);
      write_register(CSR_KD_ROLL_PITCH, s.kd_rp);
      write_register(CSR_KP_YAW, s.kp_yaw);
      write_register(CSR_KD_YAW, s.kd_yaw);
      write_register(CSR_KI_TIMES_STEP, s.ki);
      csr_valid <= 1'b0;
   endtask

   // block is idle once every queued sample is taken and answered
   task automatic wait_for_drain();
      while (samples_taken != samples_queued || expected_commands.size() != 0)
         @(posedge clock);
   endtask

   // Attitude traffic: mostly a mean-reverting walk around the setpoint
   // (errors of both signs keep the integral in range), with some uniform
   // in-range samples and some raw 15-bit patterns as noise.
   task automatic queue_samples(int count);
      int n;
      int a;
      int r;
      int v;
      int stride;
      int delta;
      int lane [3];
      for (n = 0; n < count; n++) begin
         for (a = 0; a < 3; a++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               v = $urandom_range(0, 2 * ANGLE_MAX + 1);
               if (v > ANGLE_MAX) v -= 2 * (ANGLE_MAX + 1);
            end else if (r < 16) begin
               v = $urandom_range(0, 25736);
               v -= 12868;
            end else begin
               case ($urandom_range(0, 2))
                  0:       stride = 40;
                  1:       stride = 400;
                  default: stride = 4000;
               endcase
               delta = $urandom_range(0, 2 * stride);
               delta -= stride;
               drift[a] = drift[a] * 3 / 4 + delta;
               v = int'(setpoint[a]) + drift[a];
               if (v > ANGLE_MAX) v = ANGLE_MAX;
               if (v < ANGLE_MIN) v = ANGLE_MIN;
            end
            lane[a] = v;
         end
         offer(lane[0], lane[1], lane[2]);
      end
   endtask

   // one random phase: idle, reprogram, pick idle style, queue traffic
   task automatic run_batch(controller_settings_type s, int count, bit squeeze);
      wait_for_drain();
      load_settings(s);
      req_quiet = squeeze || ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      if (squeeze) stall_requests++;
      queue_samples(count);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued measurements; valid holds until the transaction
   // is taken. Prediction runs at the accepting edge so it sees exactly the
   // register set the block uses.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_commands(current_sample);
            samples_taken++;
            req_gap = idle_gap(req_quiet);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               current_sample = sample_queue.pop_front();
               req_valid          <= 1'b1;
               req_roll_measured  <= current_sample.roll;
               req_pitch_measured <= current_sample.pitch;
               req_yaw_measured   <= current_sample.yaw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each command transaction against the oldest
   // prediction and shapes rsp_ready (random gaps plus long hold-offs).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      command_set_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               report_failure($sformatf("command %0d arrived with nothing outstanding",
                                        commands_seen));
            end else begin
               want = expected_commands.pop_front();
               if (rsp_left_aileron !== want.left_aileron)
                  report_failure($sformatf("command %0d left_aileron: got %0d, expected %0d",
                                 commands_seen, rsp_left_aileron, want.left_aileron));
               if (rsp_right_aileron !== want.right_aileron)
                  report_failure($sformatf("command %0d right_aileron: got %0d, expected %0d",
                                 commands_seen, rsp_right_aileron, want.right_aileron));
               if (rsp_elevator !== want.elevator)
                  report_failure($sformatf("command %0d elevator: got %0d, expected %0d",
                                 commands_seen, rsp_elevator, want.elevator));
               if (rsp_rudder !== want.rudder)
                  report_failure($sformatf("command %0d rudder: got %0d, expected %0d",
                                 commands_seen, rsp_rudder, want.rudder));
            end
            commands_seen++;
            rsp_gap = idle_gap(rsp_quiet);
         end
         if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            stall_left    = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake anywhere stops the run.
   always @(posedge clock) begin
      if (reset) begin
         stalled_cycles = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int k;
      // predictor starts from the register defaults and cleared state
      setpoint[0] = RST_ROLL_SETPOINT;
      setpoint[1] = RST_PITCH_SETPOINT;
      setpoint[2] = RST_YAW_SETPOINT;
      kp_gain[0]  = RST_KP_ROLL_PITCH;
      kp_gain[1]  = RST_KP_ROLL_PITCH;
      kp_gain[2]  = RST_KP_YAW;
      kd_gain[0]  = RST_KD_ROLL_PITCH;
      kd_gain[1]  = RST_KD_ROLL_PITCH;
      kd_gain[2]  = RST_KD_YAW;
      ki_gain     = RST_KI_TIMES_STEP;
      for (k = 0; k < 3; k++) begin
         integral_sum[k] = 0;
         last_error[k]   = 0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: zero error, range edges, full-scale swings
      // (largest derivative), then a held error to build the integral.
      offer(2145, 2145, 2048);
      offer(0, 0, 0);
      offer(12868, 12868, 12868);
      offer(-12868, -12868, -12868);
      offer(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
      offer(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
      offer(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);
      offer(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
      repeat (4) offer(1000, -1000, 500);

      // Rounding and clamp edges: kp of half an output LSB on roll/pitch
      // gives exact ties, kp of 1.0 on yaw puts e = +-4096 right on +-1.
      wait_for_drain();
      load_settings(make_settings(0, 0, 0, 8192, 0, 65536, 0, 0));
      offer(-1, 1, -4096);
      offer(-3, 3, 4096);
      offer(2, -2, -4095);
      offer(0, 0, 4095);

      // Every gain at full scale, roll and pitch setpoints at the rails.
      wait_for_drain();
      load_settings(make_settings(ANGLE_MAX, ANGLE_MIN, 0, GAIN_MAX, GAIN_MAX,
                                  GAIN_MAX, GAIN_MAX, GAIN_MAX));
      offer(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
      offer(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);
      offer(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
      offer(0, 0, 0);

      // Random phases. The first and a later one hold off the receiver
      // long enough for the pipe to back up into req_ready.
      run_batch(make_settings(RST_ROLL_SETPOINT, RST_PITCH_SETPOINT, RST_YAW_SETPOINT,
                              RST_KP_ROLL_PITCH, RST_KD_ROLL_PITCH, RST_KP_YAW,
                              RST_KD_YAW, RST_KI_TIMES_STEP), 350, 1'b1);
      run_batch(make_settings(random_angle(), random_angle(), random_angle(),
                              0, 0, 0, 0, 0), 200, 1'b0);
      for (k = 0; k < 5; k++)
         run_batch(random_settings(), 220, k == 2);
      run_batch(make_settings(12868, -12868, 12868, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                              GAIN_MAX, GAIN_MAX), 200, 1'b0);

      // Integral build-up: ki of one LSB and no kp/kd, maximum error held
      // so each integral grows by the full error every step (roll and yaw up,
      // pitch down), then the error is reversed for twice as long so all
      // three wind back through zero.
      wait_for_drain();
      load_settings(make_settings(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 0, 0, 0, 0, 1));
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      repeat (WINDUP_ITEMS) offer(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
      wait_for_drain();
      load_settings(make_settings(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, 0, 0, 0, 0, 1));
      repeat (2 * WINDUP_ITEMS) offer(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);

      wait_for_drain();
      // wait past the pipe depth to catch any stray transaction
      repeat (8) @(posedge clock);
      if (expected_commands.size() != 0)
         report_failure($sformatf("%0d commands never arrived", expected_commands.size()));
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/tapid_pkg.sv
hw/rtl/tapid_lane.sv
hw/rtl/tapid_merge.sv
hw/rtl/three_axis_attitude_pid.sv
test/tb_three_axis_attitude_pid.sv
